// ===== hw/rtl/plch_pkg.sv =====
package plch_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 2048;
	localparam int unsigned HDR_BYTES       = 8;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// request kinds carried on s_tuser
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_PULL = 1'b1;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// one byte of reflected CRC-32, bit at a time
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/plch_store.sv =====
module plch_store #(
	parameter int unsigned MAX_PAYLOAD = plch_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned AW          = 11
) (
	input  logic              clk,
	input  plch_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     wr_addr,
	input  logic [7:0]        wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [7:0]        rd_data
);
	import plch_pkg::*;

	logic [7:0] mem [MAX_PAYLOAD];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/plch_ctrl.sv =====
module plch_ctrl #(
	parameter int unsigned MAX_PAYLOAD = plch_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned AW          = 11,
	parameter int unsigned CW          = 12,
	parameter int unsigned PW          = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tuser,
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast,
	output plch_pkg::mem_ctl_t mem_ctl,
	output logic [AW-1:0]      wr_addr,
	output logic [7:0]         wr_data,
	output logic [AW-1:0]      rd_addr,
	input  logic [7:0]         rd_data
);
	import plch_pkg::*;

	logic          m_tvalid_q;
	logic [CW-1:0] count_q;
	logic [31:0]   crc_q;
	logic          ready_q;
	logic [PW-1:0] pos_q;

	logic [7:0]    byte_q;
	logic          sel_mem_q;
	logic          ovalid_q;
	logic          last_q;
	logic          drop_q;

	logic          accept;
	logic          is_push;
	logic          is_pull;
	logic          has_room;
	logic          frame_end;
	logic          in_hdr;
	logic [31:0]   hdr_word;
	logic [7:0]    hdr_b;
	logic [PW-1:0] total;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_push  = accept && (s_tuser == REQ_PUSH);
	assign is_pull  = accept && (s_tuser == REQ_PULL) && ready_q;
	assign has_room = count_q < CW'(MAX_PAYLOAD);

	assign total     = PW'(count_q) + PW'(HDR_BYTES);
	assign frame_end = (pos_q + PW'(1)) == total;
	assign in_hdr    = pos_q < PW'(HDR_BYTES);

	// header: length word then final CRC, both most significant byte first
	assign hdr_word = (pos_q < PW'(4)) ? 32'(count_q) : (crc_q ^ CRC_INIT);
	assign hdr_b    = 8'(hdr_word >> {2'd3 - pos_q[1:0], 3'b000});

	always_comb begin
		mem_ctl.wr_en = is_push && !ready_q && has_room;
		mem_ctl.rd_en = is_pull && !in_hdr;
	end
	assign wr_addr = AW'(count_q);
	assign wr_data = s_tdata;
	assign rd_addr = AW'(pos_q - PW'(HDR_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			count_q    <= '0;
			crc_q      <= CRC_INIT;
			ready_q    <= 1'b0;
			pos_q      <= '0;
			byte_q     <= '0;
			sel_mem_q  <= 1'b0;
			ovalid_q   <= 1'b0;
			last_q     <= 1'b0;
			drop_q     <= 1'b0;
		end else begin
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (accept) begin
				byte_q    <= '0;
				sel_mem_q <= 1'b0;
				ovalid_q  <= 1'b0;
				last_q    <= 1'b0;
				drop_q    <= 1'b0;
				if (is_push) begin
					if (ready_q) begin
						drop_q <= 1'b1;
					end else begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
							crc_q   <= crc_byte(crc_q, s_tdata);
						end else begin
							drop_q <= 1'b1;
						end
						// a last flag closes the frame even when the byte is dropped
						if (s_tlast) begin
							ready_q <= 1'b1;
							pos_q   <= '0;
						end
					end
				end else if (is_pull) begin
					ovalid_q  <= 1'b1;
					last_q    <= frame_end;
					sel_mem_q <= !in_hdr;
					byte_q    <= in_hdr ? hdr_b : 8'h00;
					if (frame_end) begin
						count_q <= '0;
						crc_q   <= CRC_INIT;
						ready_q <= 1'b0;
						pos_q   <= '0;
					end else begin
						pos_q <= pos_q + PW'(1);
					end
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = sel_mem_q ? rd_data : byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = {drop_q, ovalid_q};

endmodule

// ===== hw/rtl/packet_length_crc32_header_core.sv =====
// Latency: a result word is presented on the cycle after its request word is accepted.
// Throughput: one request word per cycle; s_tready drops only while a result is stalled.
// The payload store has a single registered read port, loaded on the same edge as the result word.
// Reset (arst_n low, asynchronous): byte count, read position and frame flag clear,
// the CRC register returns to all ones; the payload store is not cleared.
module packet_length_crc32_header_core #(
	parameter int unsigned MAX_PAYLOAD = plch_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tuser,  // [0] req_type
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic [1:0] m_tuser,  // [0] out_valid, [1] push_dropped
	output logic       m_tlast
);
	import plch_pkg::*;

	localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned PW = $clog2(MAX_PAYLOAD + HDR_BYTES + 1);

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	plch_ctrl #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.AW(AW),
		.CW(CW),
		.PW(PW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mem_ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	plch_store #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.AW(AW)
	) u_store (
		.clk(clk),
		.ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

// ===== hw/rtl/plch_checker.sv =====
module plch_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// every accepted request word gives a result word on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted request");

	// a dropped push never carries a framed byte
	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("framed byte flagged as dropped");

	// results with no framed byte are all zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata == 8'h00) && !m_tlast)
		else $error("non-zero payload on empty result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result word changed");

endmodule

bind packet_length_crc32_header_core plch_checker u_plch_checker (.*);
